/* rtl/core/holl_pkg.sv */
// Package for the hex object line loader: codes, column constants and sizes.
// Shared by the loader core, its port checker and the testbench; depends on nothing else.
package holl_pkg;

	// Memory and line sizes
	localparam int MEM_BYTES      = 4096;
	localparam int MAX_LINE_BYTES = 10;

	// Width of a byte count on one line (0..MAX_LINE_BYTES)
	localparam int CNT_W = $clog2(MAX_LINE_BYTES + 1);
	// Width of an index into the line byte buffer
	localparam int BI_W  = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

	// Fixed columns of a line
	localparam logic [4:0] DATA_COL = 5'd7;
	localparam logic [4:0] BAR_COL  = 5'd28;
	localparam logic [4:0] COL_CAP  = 5'd29;

	// Characters with a fixed meaning
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	// Input item function codes
	typedef enum logic [1:0] {
		FUNC_CHAR = 2'd0,
		FUNC_EOL  = 2'd1,
		FUNC_EOI  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	// Result item kinds
	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_ERROR  = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	// Per-line status flags
	typedef struct packed {
		logic fmt;
		logic nonblank;
		logic done;
		logic bar;
		logic col6;
	} line_flags_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Decode one ASCII hex digit; ok is low for any other character.
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

/* rtl/core/hex_object_line_loader_core.sv */
// Input: a character item is always accepted; the first result of an end-of-line or end-of-input
// item is registered and shown the cycle after it is accepted. Throughput: one character item
// per cycle; a line gives up to MAX_LINE_BYTES + 1 results, one per cycle while out_ready is
// high, and the next end-of-line or end-of-input item waits until the last one is taken.
// Reset: arst_n clears parsing and load state at once, not the buffers; no clearing pass needed.
// Loader core: parses a fixed-column hex object text into byte writes.
// Depends on holl_pkg.
module hex_object_line_loader_core import holl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [11:0] address,
	output logic [7:0]  data,
	output logic [15:0] line_index,
	output logic        loaded,
	output logic        last
);

	// Line parsing state
	logic [4:0]    col_q;
	logic [11:0]   addr_acc_q;
	logic [4:0]    dc_q;
	line_flags_t   flags_q;
	logic [7:0]    buf_q [MAX_LINE_BYTES];

	// Load state
	logic          hw_valid_q;
	logic [11:0]   hw_q;
	logic [15:0]   line_cnt_q;
	logic          halted_q;

	// Result sequence registers
	logic          pend_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] wcnt_q;
	logic [1:0]    fin_kind_q;
	logic [11:0]   eaddr_q;
	logic [15:0]   eline_q;
	logic          eloaded_q;
	logic [7:0]    ebuf_q [MAX_LINE_BYTES];

	logic          in_fire;
	logic          out_fire;
	logic          at_final;
	logic          is_line_end;

	// Next line state from a character item
	logic [4:0]    col_d;
	logic [11:0]   addr_acc_d;
	logic [4:0]    dc_d;
	line_flags_t   flags_d;
	logic          bwe;
	logic [BI_W-1:0] bidx;
	logic [7:0]    bdata;
	hex_t          hx;
	logic [3:0]    byte_idx;

	// End-of-line decision
	logic [3:0]    bytes;
	logic [12:0]   addr_sum;
	logic          line_err;

	// Handshake; only end-of-line and end-of-input items wait for the output side.
	assign at_final    = (idx_q == wcnt_q);
	assign out_valid   = pend_q;
	assign out_fire    = pend_q && out_ready;
	assign is_line_end = (func == FUNC_EOL) || (func == FUNC_EOI);
	assign in_ready    = !pend_q || (out_ready && at_final) || !is_line_end;
	assign in_fire     = in_valid && in_ready;

	// Character handling by column
	always_comb begin
		col_d      = col_q;
		addr_acc_d = addr_acc_q;
		dc_d       = dc_q;
		flags_d    = flags_q;
		bwe        = 1'b0;
		byte_idx   = dc_q[4:1];
		bidx       = byte_idx[BI_W-1:0];
		bdata      = 8'd0;
		hx         = hex_digit(char_code);
		if (col_q < COL_CAP) begin
			col_d = col_q + 5'd1;
			if (col_q >= 5'd2 && col_q < BAR_COL && char_code != CH_SPACE) begin
				flags_d.nonblank = 1'b1;
			end
			if (col_q == 5'd0) begin
				if (char_code != CH_ZERO) flags_d.fmt = 1'b1;
			end else if (col_q == 5'd1) begin
				if (char_code != CH_X) flags_d.fmt = 1'b1;
			end else if (col_q <= 5'd4) begin
				if (!hx.ok) flags_d.fmt = 1'b1;
				addr_acc_d = {addr_acc_q[7:0], hx.val};
			end else if (col_q == 5'd5) begin
				if (char_code != CH_COLON) flags_d.fmt = 1'b1;
			end else if (col_q == 5'd6) begin
				if (char_code != CH_SPACE) flags_d.col6 = 1'b1;
			end else if (col_q < BAR_COL) begin
				// Hex run, then only spaces up to the bar column.
				if (flags_q.done) begin
					if (char_code != CH_SPACE) flags_d.fmt = 1'b1;
				end else if (char_code == CH_SPACE) begin
					flags_d.done = 1'b1;
				end else if (!hx.ok) begin
					flags_d.fmt = 1'b1;
				end else begin
					if (byte_idx < 4'(MAX_LINE_BYTES)) begin
						bwe   = 1'b1;
						bdata = dc_q[0] ? {buf_q[bidx][7:4], hx.val} : {hx.val, 4'h0};
					end
					if (dc_q != 5'd31) dc_d = dc_q + 5'd1;
				end
			end else begin
				if (char_code == CH_BAR) flags_d.bar = 1'b1;
			end
		end
	end

	// Line check at end of line
	always_comb begin
		bytes    = dc_q[4:1];
		addr_sum = {1'b0, addr_acc_q} + {9'd0, bytes};
		if (col_q < COL_CAP || !flags_q.bar) begin
			line_err = 1'b1;
		end else if (flags_q.nonblank) begin
			line_err = flags_q.fmt || dc_q[0]
				|| (bytes > 4'(MAX_LINE_BYTES))
				|| (bytes != 4'd0 && flags_q.col6)
				|| (hw_valid_q && addr_acc_q <= hw_q)
				|| (addr_sum > 13'(MEM_BYTES));
		end else begin
			line_err = 1'b0;
		end
	end

	// Line and load state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			addr_acc_q <= '0;
			dc_q       <= '0;
			flags_q    <= '0;
			hw_valid_q <= 1'b0;
			hw_q       <= '0;
			line_cnt_q <= 16'd1;
			halted_q   <= 1'b0;
		end else if (in_fire) begin
			unique case (func)
				FUNC_CHAR: begin
					if (!halted_q) begin
						col_q      <= col_d;
						addr_acc_q <= addr_acc_d;
						dc_q       <= dc_d;
						flags_q    <= flags_d;
					end
				end
				FUNC_EOL: begin
					col_q      <= '0;
					addr_acc_q <= '0;
					dc_q       <= '0;
					flags_q    <= '0;
					if (!halted_q) begin
						if (line_err) begin
							halted_q <= 1'b1;
						end else begin
							if (flags_q.nonblank && bytes != 4'd0) begin
								hw_valid_q <= 1'b1;
								hw_q       <= 12'(addr_sum - 13'd1);
							end
							if (line_cnt_q != 16'hFFFF) line_cnt_q <= line_cnt_q + 16'd1;
						end
					end
				end
				FUNC_EOI: begin
					col_q      <= '0;
					addr_acc_q <= '0;
					dc_q       <= '0;
					flags_q    <= '0;
					hw_valid_q <= 1'b0;
					hw_q       <= '0;
					line_cnt_q <= 16'd1;
					halted_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Line byte buffer
	always_ff @(posedge clk) begin
		if (in_fire && func == FUNC_CHAR && !halted_q && bwe) begin
			buf_q[bidx] <= bdata;
		end
	end

	// Result sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_fire && func == FUNC_EOI) begin
			pend_q <= 1'b1;
			idx_q  <= '0;
		end else if (in_fire && func == FUNC_EOL && !halted_q) begin
			pend_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (at_final) begin
				pend_q <= 1'b0;
			end else begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// Result sequence payload, loaded when a line or the load closes
	always_ff @(posedge clk) begin
		if (in_fire && func == FUNC_EOI) begin
			wcnt_q     <= '0;
			fin_kind_q <= KIND_DONE;
			eline_q    <= '0;
			eloaded_q  <= !halted_q;
		end else if (in_fire && func == FUNC_EOL && !halted_q) begin
			fin_kind_q <= line_err ? KIND_ERROR : KIND_ACCEPT;
			wcnt_q     <= (!line_err && flags_q.nonblank) ? CNT_W'(bytes) : '0;
			eline_q    <= line_cnt_q;
			eloaded_q  <= 1'b0;
			eaddr_q    <= addr_acc_q;
			ebuf_q     <= buf_q;
		end
	end

	// Result fields: byte writes first, then the closing result
	always_comb begin
		if (at_final) begin
			kind       = fin_kind_q;
			address    = 12'd0;
			data       = 8'd0;
			line_index = eline_q;
			loaded     = eloaded_q;
			last       = 1'b1;
		end else begin
			kind       = KIND_WRITE;
			address    = eaddr_q + 12'(idx_q);
			data       = ebuf_q[idx_q[BI_W-1:0]];
			line_index = 16'd0;
			loaded     = 1'b0;
			last       = 1'b0;
		end
	end

endmodule

/* rtl/core/holl_chk.sv */
// Port checker for the loader core, attached to it by the bind below.
// Depends on holl_pkg and hex_object_line_loader_core.
module holl_chk import holl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [11:0] address,
	input logic [7:0]  data,
	input logic [15:0] line_index,
	input logic        loaded,
	input logic        last
);

	// A stalled result item stays valid and holds its kind, address, data and last.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(address)
			&& $stable(data) && $stable(last))
		else $error("result item changed while stalled");

	// A byte write is never the final result of an item.
	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_WRITE |-> !last)
		else $error("byte write marked last");

	// Every result other than a byte write closes its item.
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_WRITE |-> last)
		else $error("closing result not marked last");

	// Line results carry a line number; only load finished carries a loaded flag.
	a_line_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ACCEPT || kind == KIND_ERROR)
			|-> line_index != 16'd0 && !loaded)
		else $error("line result without line number");

endmodule

bind hex_object_line_loader_core holl_chk u_holl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.address    (address),
	.data       (data),
	.line_index (line_index),
	.loaded     (loaded),
	.last       (last)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for hex_object_line_loader_core: a directed table of object lines, then
// random loads, all checked against an in-bench parser of the line format. Needs holl_pkg.
module testbench;
	import holl_pkg::*;

	localparam int QUIET_LIMIT      = 2000;
	localparam int LONG_HOLD        = 400;
	localparam int DRAIN_CYCLES     = 16;
	localparam int RANDOM_ITEMS     = 230;
	localparam int RANDOM_EVENTS    = 60;
	localparam int QUIET_TAIL_ITEMS = 180;

	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	// One result item as the loader should emit it.
	typedef struct {
		kind_t       kind;
		logic [11:0] address;
		logic [7:0]  data;
		logic [15:0] line_index;
		logic        loaded;
		logic        last;
	} load_event_t;

	// One row of the directed table: a line body, optional padding to the bar column,
	// a tail, the closing item, and an optional typed result for that closing item.
	typedef struct {
		string body;
		bit    pad;
		string tail;
		func_t term;
		bit    typed;
		kind_t kind;
		int    line;
		bit    loaded;
	} line_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [11:0] address;
	logic [7:0]  data;
	logic [15:0] line_index;
	logic        loaded;
	logic        last;

	// Parser state mirrored in the bench.
	int          col_pos;
	logic [11:0] addr_acc;
	logic [7:0]  line_bytes [MAX_LINE_BYTES];
	int          digit_cnt;
	bit          fmt_bad, nonblank, run_done, bar_seen, col6_bad;
	int          top_written;
	logic [15:0] line_no;
	bit          stopped;

	load_event_t load_events [$];
	load_event_t last_event;
	line_row_t   line_rows [$];
	int          items_taken;
	int          events_made;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          idle_on = 1'b1;
	bit          hold_request = 1'b0;

	hex_object_line_loader_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.address    (address),
		.data       (data),
		.line_index (line_index),
		.loaded     (loaded),
		.last       (last)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decode one hex digit character; returns 0 for anything else.
	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
		v = 4'h0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = 4'(c - CH_ZERO);
			return 1'b1;
		end
		if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			v = 4'(c - CH_LOWER_A + 8'd10);
			return 1'b1;
		end
		if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			v = 4'(c - CH_UPPER_A + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Hex digit character for a nibble, letters in random case.
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			return CH_ZERO + 8'(v);
		end
		return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
	endfunction

	task automatic push_event(kind_t k, int adr, int dat, int ln, bit ld, bit lst);
		load_event_t e;
		e.kind       = k;
		e.address    = 12'(adr);
		e.data       = 8'(dat);
		e.line_index = 16'(ln);
		e.loaded     = ld;
		e.last       = lst;
		load_events.push_back(e);
		last_event = e;
		events_made++;
	endtask

	task automatic clear_line_state();
		col_pos   = 0;
		addr_acc  = 12'h000;
		digit_cnt = 0;
		fmt_bad   = 1'b0;
		nonblank  = 1'b0;
		run_done  = 1'b0;
		bar_seen  = 1'b0;
		col6_bad  = 1'b0;
	endtask

	task automatic restart_load();
		clear_line_state();
		top_written = -1;
		line_no     = 16'd1;
		stopped     = 1'b0;
	endtask

	// Column rules for one character of a line.
	task automatic parse_char(logic [7:0] c);
		int          k;
		int          idx;
		logic [3:0]  v;
		bit          ok;
		k = col_pos;
		col_pos++;
		if (k >= 2 && k < BAR_COL && c != CH_SPACE) nonblank = 1'b1;
		if (k == 0) begin
			if (c != CH_ZERO) fmt_bad = 1'b1;
		end else if (k == 1) begin
			if (c != CH_X) fmt_bad = 1'b1;
		end else if (k <= 4) begin
			ok = hex_nibble(c, v);
			if (!ok) fmt_bad = 1'b1;
			addr_acc = {addr_acc[7:0], v};
		end else if (k == 5) begin
			if (c != CH_COLON) fmt_bad = 1'b1;
		end else if (k == 6) begin
			if (c != CH_SPACE) col6_bad = 1'b1;
		end else if (k < BAR_COL) begin
			if (run_done) begin
				if (c != CH_SPACE) fmt_bad = 1'b1;
			end else if (c == CH_SPACE) begin
				run_done = 1'b1;
			end else begin
				ok = hex_nibble(c, v);
				if (!ok) begin
					fmt_bad = 1'b1;
				end else begin
					idx = digit_cnt >> 1;
					if (idx < MAX_LINE_BYTES) begin
						if (digit_cnt % 2 == 0) line_bytes[idx] = {v, 4'h0};
						else line_bytes[idx][3:0] = v;
					end
					if (digit_cnt < 31) digit_cnt++;
				end
			end
		end else begin
			if (c == CH_BAR) bar_seen = 1'b1;
		end
	endtask

	// Line end: judge the line and emit its writes and its verdict.
	task automatic close_line();
		int nb;
		int a;
		bit err;
		nb = digit_cnt >> 1;
		a  = int'(addr_acc);
		if (col_pos < COL_CAP || !bar_seen) begin
			err = 1'b1;
		end else if (nonblank) begin
			err = fmt_bad || (digit_cnt % 2 != 0) || nb > MAX_LINE_BYTES
				|| (nb > 0 && col6_bad) || a <= top_written || a + nb > MEM_BYTES;
		end else begin
			err = 1'b0;
		end
		if (err) begin
			push_event(KIND_ERROR, 0, 0, line_no, 1'b0, 1'b1);
			stopped = 1'b1;
		end else begin
			if (nonblank && nb > 0) begin
				for (int i = 0; i < nb; i++) begin
					push_event(KIND_WRITE, a + i, line_bytes[i], 0, 1'b0, 1'b0);
				end
				top_written = a + nb - 1;
			end
			push_event(KIND_ACCEPT, 0, 0, line_no, 1'b0, 1'b1);
			if (line_no != 16'hFFFF) line_no++;
		end
		clear_line_state();
	endtask

	// Work out the results of one accepted item; counts items that have any effect.
	task automatic parse_item(func_t f, logic [7:0] c);
		case (f)
			FUNC_CHAR: begin
				if (!stopped && col_pos < COL_CAP) begin
					parse_char(c);
					items_taken++;
				end
			end
			FUNC_EOL: begin
				if (stopped) begin
					clear_line_state();
				end else begin
					close_line();
					items_taken++;
				end
			end
			FUNC_EOI: begin
				push_event(KIND_DONE, 0, 0, 0, !stopped, 1'b1);
				restart_load();
				items_taken++;
			end
			default: ;
		endcase
	endtask

	// Offer one item, possibly after a burst of idle cycles, and wait for its acceptance.
	task automatic send_item(func_t f, logic [7:0] c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid  = 1'b1;
		func      = f;
		char_code = c;
		do @(posedge clk); while (!in_ready);
		parse_item(f, c);
		@(negedge clk);
	endtask

	// Mostly well-formed data or comment lines with random content; some are damaged.
	task automatic send_random_line();
		logic [7:0] txt [$];
		int         sel;
		int         nb;
		int         a;
		int         pos;
		sel = $urandom_range(0, 99);
		nb  = 0;
		txt = {CH_ZERO, CH_X};
		if (sel < 10) begin
			repeat (BAR_COL - 2) txt.push_back(CH_SPACE);
		end else begin
			nb = $urandom_range(0, MAX_LINE_BYTES);
			if (top_written >= MEM_BYTES - 1 || $urandom_range(0, 9) == 0) begin
				a = $urandom_range(0, MEM_BYTES - 1);
			end else if ($urandom_range(0, 7) == 0) begin
				a = $urandom_range(top_written + 1, MEM_BYTES - 1);
			end else begin
				a = top_written + 1 + $urandom_range(0, 2);
			end
			if (a > MEM_BYTES - 1) a = MEM_BYTES - 1;
			txt.push_back(hex_char(a[11:8]));
			txt.push_back(hex_char(a[7:4]));
			txt.push_back(hex_char(a[3:0]));
			txt.push_back(CH_COLON);
			txt.push_back(CH_SPACE);
			repeat (2 * nb) txt.push_back(hex_char(4'($urandom_range(0, 15))));
			while (txt.size() < BAR_COL) txt.push_back(CH_SPACE);
		end
		txt.push_back(CH_BAR);
		// Damage: a stray byte, a short line, a used column 6, or an odd digit run.
		if (sel >= 78) begin
			case ($urandom_range(0, 3))
				0: begin
					pos = $urandom_range(0, BAR_COL);
					txt[pos] = 8'($urandom_range(0, 255));
				end
				1: begin
					pos = $urandom_range(0, BAR_COL - 1);
					txt = txt[0:pos];
				end
				2: txt[6] = hex_char(4'($urandom_range(0, 15)));
				default: txt[DATA_COL + 2 * nb] = hex_char(4'($urandom_range(0, 15)));
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
		end
		foreach (txt[i]) send_item(FUNC_CHAR, txt[i]);
		send_item(FUNC_EOL, 8'($urandom_range(0, 255)));
	endtask

	// Stimulus: reset, directed table, random loads, then drain and verdict.
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = FUNC_CHAR;
		char_code = 8'h00;
		restart_load();

		// First load: good lines, a comment, an empty run, trailing text, top address.
		line_rows.push_back('{"0x000: 00ff", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ACCEPT, 1, 1'b0});
		line_rows.push_back('{"0x010: 0123456789abcdefABCD", 1'b1, "|", FUNC_EOL,
			1'b1, KIND_ACCEPT, 2, 1'b0});
		line_rows.push_back('{"0x", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ACCEPT, 3, 1'b0});
		line_rows.push_back('{"0x020:Z", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ACCEPT, 4, 1'b0});
		line_rows.push_back('{"0x021: 7e", 1'b1, "|~trailing", FUNC_EOL,
			1'b1, KIND_ACCEPT, 5, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_NONE, 1'b0, KIND_WRITE, 0, 1'b0});
		line_rows.push_back('{"0xFFF: 5A", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ACCEPT, 6, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b1});
		// Short line halts the load; the next line gives nothing.
		line_rows.push_back('{"0x000: 11", 1'b1, "", FUNC_EOL, 1'b1, KIND_ERROR, 1, 1'b0});
		line_rows.push_back('{"0x001: 22", 1'b1, "|", FUNC_EOL, 1'b0, KIND_WRITE, 0, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b0});
		// Odd digit count.
		line_rows.push_back('{"0x005: 123", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ERROR, 1, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b0});
		// Bytes run past the end of memory.
		line_rows.push_back('{"0xff8: 000102030405060708", 1'b1, "|", FUNC_EOL,
			1'b1, KIND_ERROR, 1, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b0});
		// Text after the end of the data run.
		line_rows.push_back('{"0x100: 12 3", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ERROR, 1, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b0});
		// Address that does not rise.
		line_rows.push_back('{"0x100: 12", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ACCEPT, 1, 1'b0});
		line_rows.push_back('{"0x100: 34", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ERROR, 2, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b0});
		// Bad prefix, address and colon, and no bar in the bar column.
		line_rows.push_back('{"0X1g0- 12", 1'b1, "X", FUNC_EOL, 1'b1, KIND_ERROR, 1, 1'b0});
		line_rows.push_back('{"", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b0});
		// Unfinished line dropped at end of input; the new load starts from scratch.
		line_rows.push_back('{"0x0a0: ab", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ACCEPT, 1, 1'b0});
		line_rows.push_back('{"0x2", 1'b0, "", FUNC_EOI, 1'b1, KIND_DONE, 0, 1'b1});
		line_rows.push_back('{"0x000: c3", 1'b1, "|", FUNC_EOL, 1'b1, KIND_ACCEPT, 1, 1'b0});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		foreach (line_rows[r]) begin
			for (int i = 0; i < line_rows[r].body.len(); i++) begin
				send_item(FUNC_CHAR, line_rows[r].body[i]);
			end
			if (line_rows[r].pad) begin
				for (int i = line_rows[r].body.len(); i < BAR_COL; i++) begin
					send_item(FUNC_CHAR, CH_SPACE);
				end
			end
			for (int i = 0; i < line_rows[r].tail.len(); i++) begin
				send_item(FUNC_CHAR, line_rows[r].tail[i]);
			end
			send_item(line_rows[r].term, 8'($urandom_range(0, 255)));
			if (line_rows[r].typed && (last_event.kind != line_rows[r].kind
					|| last_event.line_index != 16'(line_rows[r].line)
					|| last_event.loaded != line_rows[r].loaded)) begin
				$error("row %0d: parser gives kind %0d line %0d loaded %0d", r,
					last_event.kind, last_event.line_index, last_event.loaded);
				mismatches++;
			end
		end

		// Random loads; the receiver first holds off so that the input backs up.
		items_taken  = 0;
		events_made  = 0;
		hold_request = 1'b1;
		while (items_taken < RANDOM_ITEMS || events_made < RANDOM_EVENTS) begin
			repeat ($urandom_range(1, 8)) begin
				send_random_line();
				if ($urandom_range(0, 9) == 0) send_item(FUNC_NONE, 8'($urandom_range(0, 255)));
				if (items_taken >= QUIET_TAIL_ITEMS) idle_on = 1'b0;
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 20)) send_item(FUNC_CHAR, 8'($urandom_range(0, 255)));
			end
			send_item(FUNC_EOI, 8'($urandom_range(0, 255)));
		end

		// Drain and verdict.
		in_valid = 1'b0;
		while (load_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// Receiver: one long hold-off on request, otherwise random stall bursts.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end
			if (idle_on && $urandom_range(0, 9) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	function automatic void compare_field(string name, int unsigned exp, int unsigned act);
		if (exp != act) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp, act);
			mismatches++;
		end
	endfunction

	// Compare each result item with the oldest expected one.
	always @(posedge clk) begin : check_results
		load_event_t e;
		if (arst_n && out_valid && out_ready) begin
			if (load_events.size() == 0) begin
				$error("unexpected result item: kind %0d address %0d line %0d",
					kind, address, line_index);
				mismatches++;
			end else begin
				e = load_events.pop_front();
				compare_field("kind", e.kind, kind);
				compare_field("address", e.address, address);
				compare_field("data", e.data, data);
				compare_field("line_index", e.line_index, line_index);
				compare_field("loaded", e.loaded, loaded);
				compare_field("last", e.last, last);
			end
		end
	end

	// Watchdog on cycles in which no item moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

endmodule

/* files.f */
rtl/core/holl_pkg.sv
rtl/core/hex_object_line_loader_core.sv
rtl/core/holl_chk.sv
sim/testbench.sv
